// ===== design/trajectory_kinematics_estimator_defines.svh =====
// Assertion macros shared by the trajectory kinematics estimator RTL.
`ifndef TRAJECTORY_KINEMATICS_ESTIMATOR_DEFINES_SVH
`define TRAJECTORY_KINEMATICS_ESTIMATOR_DEFINES_SVH

// Implication checked in the same cycle.
`define TKE_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Implication checked in the next cycle.
`define TKE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/tke_pkg.sv =====
// Types, constants and helper functions of the trajectory kinematics estimator.
`default_nettype none
package tke_pkg;

  // Register indexes on the configuration port
  localparam logic [1:0] REG_MIN_INTERVAL = 2'd0;
  localparam logic [1:0] REG_GRIP_LIMIT   = 2'd1;
  localparam logic [1:0] REG_RISK_ONSET   = 2'd2;

  localparam logic [19:0] MIN_INTERVAL_RST = 20'd1000;
  localparam logic [16:0] GRIP_LIMIT_RST   = 17'd7848;
  localparam logic [15:0] RISK_ONSET_RST   = 16'd39322;

  localparam logic [32:0] US_PER_S = 33'd1000000;

  // Shared divider widths: dividend up to 2^52 plus rounding, divisor up to 2^34
  localparam int DIV_DVD_W = 53;
  localparam int DIV_DVS_W = 34;

  localparam logic [4:0] CORDIC_LAST = 5'd30;

  typedef enum logic [4:0] {
    ST_IDLE, ST_START, ST_NEW, ST_DT, ST_RMUL, ST_RADD, ST_RGO, ST_RWAIT,
    ST_ACC, ST_FINAL, ST_COMMIT,
    ST_E_SQ1, ST_E_SQ2, ST_E_SQRT, ST_E_RND, ST_E_COR0, ST_E_COR, ST_E_CORF,
    ST_E_RISK0, ST_E_RISK1, ST_E_RISK2, ST_E_RISK3, ST_E_RGO, ST_E_RWAIT, ST_E_OUT
  } st_t;

  typedef enum logic [1:0] {TGT_VX, TGT_VY, TGT_AX, TGT_AY} tgt_t;

  typedef struct packed {
    logic busy;
    logic done;
  } tke_div_stat_t;

  // CORDIC arctangent table, 2^32 = full turn
  function automatic logic [31:0] atan_ent(input logic [4:0] i);
    logic [31:0] r;
    case (i)
      5'd0:  r = 32'd536870912;
      5'd1:  r = 32'd316933406;
      5'd2:  r = 32'd167458907;
      5'd3:  r = 32'd85004756;
      5'd4:  r = 32'd42667331;
      5'd5:  r = 32'd21354465;
      5'd6:  r = 32'd10679838;
      5'd7:  r = 32'd5340245;
      5'd8:  r = 32'd2670163;
      5'd9:  r = 32'd1335087;
      5'd10: r = 32'd667544;
      5'd11: r = 32'd333772;
      5'd12: r = 32'd166886;
      5'd13: r = 32'd83443;
      5'd14: r = 32'd41722;
      5'd15: r = 32'd20861;
      5'd16: r = 32'd10430;
      5'd17: r = 32'd5215;
      5'd18: r = 32'd2608;
      5'd19: r = 32'd1304;
      5'd20: r = 32'd652;
      5'd21: r = 32'd326;
      5'd22: r = 32'd163;
      5'd23: r = 32'd81;
      5'd24: r = 32'd41;
      5'd25: r = 32'd20;
      5'd26: r = 32'd10;
      5'd27: r = 32'd5;
      5'd28: r = 32'd3;
      5'd29: r = 32'd1;
      5'd30: r = 32'd1;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

  // Apply sign to a rate quotient and saturate to 32-bit signed
  function automatic logic [31:0] sat_rate(input logic [52:0] q, input logic neg);
    logic [31:0] r;
    if (neg) begin
      if (q > 53'h80000000) r = 32'h80000000;
      else r = ~q[31:0] + 32'd1;
    end else begin
      if (q > 53'h7fffffff) r = 32'h7fffffff;
      else r = q[31:0];
    end
    return r;
  endfunction

  // Magnitude of a 32-bit signed value
  function automatic logic [32:0] abs33(input logic [31:0] v);
    logic [32:0] e;
    e = {v[31], v};
    return v[31] ? (~e + 33'd1) : e;
  endfunction

endpackage
`default_nettype wire

// ===== design/trajectory_kinematics_estimator.sv =====
// Top level of the trajectory kinematics estimator.
//
// Input stream: one position sample per transfer (time, x, y in tdata, track
// start in tuser, track end in tlast). Result stream: velocity, speed,
// heading, acceleration, its magnitude and the stability risk per transfer,
// first-sample flag in tuser, last result of the sample in tlast.
// A sample yields zero, one or two results. The first sample of a track is
// held back until the second one or the next track start, unless it ends its track.
// Work runs on one multiplier, one restoring divider, a 32-step square root
// and a 31-step CORDIC under a sequencer; in_tready is high only when the
// sequencer is idle, so a new sample is taken only after the last one is done.
// Registers are to be written over the APB-style port only while the block is
// idle; the block itself does not enforce this. Reset clears the track history
// and loads the register defaults.
// A result waits in the output register while the receiver stalls; the
// sequencer stalls only when the next result is ready and that register is full.
`default_nettype none
`include "trajectory_kinematics_estimator_defines.svh"
module trajectory_kinematics_estimator
  import tke_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [95:0]  in_tdata,  // sample_time_us, pos_x_mm, pos_y_mm
  input  wire logic         in_tuser,  // track_start
  input  wire logic         in_tlast,  // track_end
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // vel_x, vel_y, speed_mag, heading_angle, acc_x, acc_y, acc_norm,
  // slip_risk, zero fill
  output logic [231:0]      out_tdata,
  output logic              out_tuser, // is_first_sample
  output logic              out_tlast, // run_last
  input  wire logic         cfg_psel,
  input  wire logic         cfg_penable,
  input  wire logic         cfg_pwrite,
  input  wire logic [3:0]   cfg_paddr,
  input  wire logic [31:0]  cfg_pwdata,
  output logic [31:0]       cfg_prdata,
  output logic              cfg_pready
);
  st_t state_r, state_nxt, ret_r, ret_nxt;
  tgt_t tgt_r, tgt_nxt;

  logic [19:0] min_r;
  logic [16:0] grip_r, g_eff;
  logic [15:0] frac_r;

  logic [31:0] t_r, t_nxt, ptime_r, ptime_nxt;
  logic signed [31:0] px_r, px_nxt, py_r, py_nxt, ppx_r, ppx_nxt, ppy_r, ppy_nxt;
  logic signed [31:0] pvx_r, pvx_nxt, pvy_r, pvy_nxt, pax_r, pax_nxt, pay_r, pay_nxt;
  logic signed [31:0] vx_r, vx_nxt, vy_r, vy_nxt, ax_r, ax_nxt, ay_r, ay_nxt;
  logic start_r, start_nxt, end_r, end_nxt;
  logic [1:0] seen_r, seen_nxt;
  logic pend_r, pend_nxt, upd_r, upd_nxt, msel_r, msel_nxt;
  logic efirst_r, efirst_nxt, elast_r, elast_nxt;
  logic signed [32:0] dt_r, dt_nxt, num_r, num_nxt;
  logic [63:0] sq_r, sq_nxt, rt_r, rt_nxt, sbit, trial, rnd;
  logic [4:0] k_r, k_nxt;
  logic signed [34:0] cx_r, cx_nxt, cy_r, cy_nxt, ex, ey, xs, ys;
  logic [31:0] z_r, z_nxt, zr;
  logic [31:0] speed_r, speed_nxt, amag_r, amag_nxt;
  logic [15:0] head_r, head_nxt;
  logic [32:0] onset_r, onset_nxt, a16;
  logic [16:0] risk_r, risk_nxt;
  logic [52:0] dvd_r, dvd_nxt, quot;
  logic [33:0] dvs_r, dvs_nxt;
  logic div_go;
  tke_div_stat_t dv_stat;
  logic upd_c;

  logic [32:0] mul_a, mul_b;
  logic [65:0] prod;

  logic oval_r, oval_nxt, load_out;
  logic signed [31:0] ovx_r, ovy_r, oax_r, oay_r;
  logic [31:0] ospeed_r, oamag_r;
  logic [15:0] ohead_r;
  logic [16:0] orisk_r;
  logic ofirst_r, olast_r;

  // configuration port
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_r  <= MIN_INTERVAL_RST;
      grip_r <= GRIP_LIMIT_RST;
      frac_r <= RISK_ONSET_RST;
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      case (cfg_paddr[3:2])
        REG_MIN_INTERVAL: min_r  <= cfg_pwdata[19:0];
        REG_GRIP_LIMIT:   grip_r <= cfg_pwdata[16:0];
        REG_RISK_ONSET:   frac_r <= cfg_pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[3:2])
      REG_MIN_INTERVAL: cfg_prdata = {12'd0, min_r};
      REG_GRIP_LIMIT:   cfg_prdata = {15'd0, grip_r};
      REG_RISK_ONSET:   cfg_prdata = {16'd0, frac_r};
      default:          cfg_prdata = 32'd0;
    endcase
  end
  assign cfg_pready = 1'b1;

  assign g_eff = (grip_r == 17'd0) ? 17'd1 : grip_r;

  // shared multiplier, operands chosen by the sequencer state
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      ST_RMUL: begin
        mul_a = num_r[32] ? 33'(-num_r) : 33'(num_r);
        mul_b = US_PER_S;
      end
      ST_E_SQ1: begin
        mul_a = abs33(msel_r ? ax_r : vx_r);
        mul_b = mul_a;
      end
      ST_E_SQ2: begin
        mul_a = abs33(msel_r ? ay_r : vy_r);
        mul_b = mul_a;
      end
      ST_E_RISK0: begin
        mul_a = {17'd0, frac_r};
        mul_b = {16'd0, g_eff};
      end
      ST_E_RISK2: begin
        mul_a = {16'd0, 17'h10000 - {1'b0, frac_r}};
        mul_b = {16'd0, g_eff};
      end
      default: ;
    endcase
  end
  assign prod = mul_a * mul_b;

  tke_div #(
    .DVD_W(DIV_DVD_W),
    .DVS_W(DIV_DVS_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .go       (div_go),
    .dividend (dvd_r),
    .divisor  (dvs_r),
    .quotient (quot),
    .stat     (dv_stat)
  );

  // datapath helpers
  assign upd_c = dt_r > $signed({13'd0, min_r});
  assign sbit  = 64'd1 << {k_r, 1'b0};
  assign trial = rt_r + sbit;
  assign rnd   = (sq_r > rt_r) ? rt_r + 64'd1 : rt_r;
  assign ex    = {{3{vx_r[31]}}, vx_r};
  assign ey    = {{3{vy_r[31]}}, vy_r};
  assign xs    = cx_r >>> k_r;
  assign ys    = cy_r >>> k_r;
  assign zr    = z_r + 32'h8000;
  assign a16   = {amag_r[16:0], 16'd0};

  assign in_tready = (state_r == ST_IDLE);

  // sequencer: next state and datapath updates
  always_comb begin
    state_nxt = state_r;  ret_nxt = ret_r;  tgt_nxt = tgt_r;
    t_nxt = t_r;  px_nxt = px_r;  py_nxt = py_r;
    start_nxt = start_r;  end_nxt = end_r;
    ptime_nxt = ptime_r;  ppx_nxt = ppx_r;  ppy_nxt = ppy_r;
    pvx_nxt = pvx_r;  pvy_nxt = pvy_r;  pax_nxt = pax_r;  pay_nxt = pay_r;
    vx_nxt = vx_r;  vy_nxt = vy_r;  ax_nxt = ax_r;  ay_nxt = ay_r;
    seen_nxt = seen_r;  pend_nxt = pend_r;  upd_nxt = upd_r;  msel_nxt = msel_r;
    efirst_nxt = efirst_r;  elast_nxt = elast_r;
    dt_nxt = dt_r;  num_nxt = num_r;
    sq_nxt = sq_r;  rt_nxt = rt_r;  k_nxt = k_r;
    cx_nxt = cx_r;  cy_nxt = cy_r;  z_nxt = z_r;
    speed_nxt = speed_r;  amag_nxt = amag_r;  head_nxt = head_r;
    onset_nxt = onset_r;  risk_nxt = risk_r;
    dvd_nxt = dvd_r;  dvs_nxt = dvs_r;
    div_go = 1'b0;
    load_out = 1'b0;
    oval_nxt = oval_r && !out_tready;

    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          t_nxt = in_tdata[31:0];
          px_nxt = in_tdata[63:32];
          py_nxt = in_tdata[95:64];
          start_nxt = in_tuser;
          end_nxt = in_tlast;
          state_nxt = ST_START;
        end
      end
      // flush a waiting first sample when a new track starts
      ST_START: begin
        state_nxt = ST_NEW;
        if (start_r) begin
          seen_nxt = 2'd0;
          pend_nxt = 1'b0;
          if (pend_r) begin
            vx_nxt = '0;  vy_nxt = '0;  ax_nxt = '0;  ay_nxt = '0;
            efirst_nxt = 1'b1;  elast_nxt = 1'b0;
            ret_nxt = ST_NEW;  msel_nxt = 1'b0;
            state_nxt = ST_E_SQ1;
          end
        end
      end
      ST_NEW: begin
        if (seen_r == 2'd0) begin
          ptime_nxt = t_r;  ppx_nxt = px_r;  ppy_nxt = py_r;
          pvx_nxt = '0;  pvy_nxt = '0;  pax_nxt = '0;  pay_nxt = '0;
          if (end_r) begin
            vx_nxt = '0;  vy_nxt = '0;  ax_nxt = '0;  ay_nxt = '0;
            efirst_nxt = 1'b1;  elast_nxt = 1'b1;
            ret_nxt = ST_IDLE;  msel_nxt = 1'b0;
            pend_nxt = 1'b0;
            state_nxt = ST_E_SQ1;
          end else begin
            seen_nxt = 2'd1;
            pend_nxt = 1'b1;
            state_nxt = ST_IDLE;
          end
        end else begin
          dt_nxt = $signed({1'b0, t_r}) - $signed({1'b0, ptime_r});
          state_nxt = ST_DT;
        end
      end
      ST_DT: begin
        upd_nxt = upd_c;
        if (upd_c) begin
          num_nxt = $signed({px_r[31], px_r}) - $signed({ppx_r[31], ppx_r});
          tgt_nxt = TGT_VX;
          state_nxt = ST_RMUL;
        end else begin
          vx_nxt = pvx_r;  vy_nxt = pvy_r;
          state_nxt = ST_ACC;
        end
      end
      // rate = |diff| * 1e6 / dt, rounded, via the shared divider
      ST_RMUL: begin
        dvd_nxt = prod[52:0];
        state_nxt = ST_RADD;
      end
      ST_RADD: begin
        dvd_nxt = dvd_r + {21'd0, dt_r[32:1]};
        dvs_nxt = {2'd0, dt_r[31:0]};
        state_nxt = ST_RGO;
      end
      ST_RGO: begin
        div_go = 1'b1;
        state_nxt = ST_RWAIT;
      end
      ST_RWAIT: begin
        if (dv_stat.done) begin
          case (tgt_r)
            TGT_VX: begin
              vx_nxt = sat_rate(quot, num_r[32]);
              num_nxt = $signed({py_r[31], py_r}) - $signed({ppy_r[31], ppy_r});
              tgt_nxt = TGT_VY;
              state_nxt = ST_RMUL;
            end
            TGT_VY: begin
              vy_nxt = sat_rate(quot, num_r[32]);
              state_nxt = ST_ACC;
            end
            TGT_AX: begin
              ax_nxt = sat_rate(quot, num_r[32]);
              num_nxt = $signed({vy_r[31], vy_r}) - $signed({pvy_r[31], pvy_r});
              tgt_nxt = TGT_AY;
              state_nxt = ST_RMUL;
            end
            TGT_AY: begin
              ay_nxt = sat_rate(quot, num_r[32]);
              state_nxt = ST_FINAL;
            end
            default: state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_ACC: begin
        if (seen_r == 2'd1) begin
          ax_nxt = '0;  ay_nxt = '0;
          state_nxt = ST_FINAL;
          if (pend_r) begin
            efirst_nxt = 1'b1;  elast_nxt = 1'b0;
            ret_nxt = ST_FINAL;  msel_nxt = 1'b0;
            state_nxt = ST_E_SQ1;
          end
        end else if (upd_r) begin
          num_nxt = $signed({vx_r[31], vx_r}) - $signed({pvx_r[31], pvx_r});
          tgt_nxt = TGT_AX;
          state_nxt = ST_RMUL;
        end else begin
          ax_nxt = pax_r;  ay_nxt = pay_r;
          state_nxt = ST_FINAL;
        end
      end
      ST_FINAL: begin
        efirst_nxt = 1'b0;  elast_nxt = 1'b1;
        ret_nxt = ST_COMMIT;  msel_nxt = 1'b0;
        state_nxt = ST_E_SQ1;
      end
      ST_COMMIT: begin
        ptime_nxt = t_r;  ppx_nxt = px_r;  ppy_nxt = py_r;
        pvx_nxt = vx_r;  pvy_nxt = vy_r;  pax_nxt = ax_r;  pay_nxt = ay_r;
        seen_nxt = end_r ? 2'd0 : 2'd2;
        pend_nxt = 1'b0;
        state_nxt = ST_IDLE;
      end
      // sum of squares for the magnitude
      ST_E_SQ1: begin
        sq_nxt = prod[63:0];
        state_nxt = ST_E_SQ2;
      end
      ST_E_SQ2: begin
        sq_nxt = sq_r + prod[63:0];
        rt_nxt = '0;
        k_nxt = 5'd31;
        state_nxt = ST_E_SQRT;
      end
      // bit-pair square root, one result bit per cycle
      ST_E_SQRT: begin
        if (sq_r >= trial) begin
          sq_nxt = sq_r - trial;
          rt_nxt = (rt_r >> 1) + sbit;
        end else begin
          rt_nxt = rt_r >> 1;
        end
        if (k_r == 5'd0) state_nxt = ST_E_RND;
        else k_nxt = k_r - 5'd1;
      end
      ST_E_RND: begin
        if (!msel_r) begin
          speed_nxt = rnd[31:0];
          state_nxt = ST_E_COR0;
        end else begin
          amag_nxt = rnd[31:0];
          state_nxt = ST_E_RISK0;
        end
      end
      // heading: half-turn pre-rotation, then CORDIC vectoring
      ST_E_COR0: begin
        if (vx_r == 32'sd0 && vy_r == 32'sd0) begin
          head_nxt = '0;
          msel_nxt = 1'b1;
          state_nxt = ST_E_SQ1;
        end else begin
          cx_nxt = vx_r[31] ? -ex : ex;
          cy_nxt = vx_r[31] ? -ey : ey;
          z_nxt = vx_r[31] ? 32'h80000000 : 32'd0;
          k_nxt = 5'd0;
          state_nxt = ST_E_COR;
        end
      end
      ST_E_COR: begin
        if (!cy_r[34]) begin
          cx_nxt = cx_r + ys;
          cy_nxt = cy_r - xs;
          z_nxt = z_r + atan_ent(k_r);
        end else begin
          cx_nxt = cx_r - ys;
          cy_nxt = cy_r + xs;
          z_nxt = z_r - atan_ent(k_r);
        end
        if (k_r == CORDIC_LAST) state_nxt = ST_E_CORF;
        else k_nxt = k_r + 5'd1;
      end
      ST_E_CORF: begin
        head_nxt = zr[31:16];
        msel_nxt = 1'b1;
        state_nxt = ST_E_SQ1;
      end
      // friction-circle risk
      ST_E_RISK0: begin
        if (amag_r >= {15'd0, g_eff}) begin
          risk_nxt = 17'h10000;
          state_nxt = ST_E_OUT;
        end else begin
          onset_nxt = prod[32:0];
          state_nxt = ST_E_RISK1;
        end
      end
      ST_E_RISK1: begin
        if (a16 <= onset_r) begin
          risk_nxt = '0;
          state_nxt = ST_E_OUT;
        end else begin
          dvd_nxt = {4'd0, a16 - onset_r, 16'd0};
          state_nxt = ST_E_RISK2;
        end
      end
      ST_E_RISK2: begin
        dvs_nxt = prod[33:0];
        state_nxt = ST_E_RISK3;
      end
      ST_E_RISK3: begin
        dvd_nxt = dvd_r + {20'd0, dvs_r[33:1]};
        state_nxt = ST_E_RGO;
      end
      ST_E_RGO: begin
        div_go = 1'b1;
        state_nxt = ST_E_RWAIT;
      end
      ST_E_RWAIT: begin
        if (dv_stat.done) begin
          risk_nxt = quot[16:0];
          state_nxt = ST_E_OUT;
        end
      end
      // hand the result to the output register once it is free
      ST_E_OUT: begin
        if (!oval_r || out_tready) begin
          load_out = 1'b1;
          oval_nxt = 1'b1;
          state_nxt = ret_r;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      seen_r  <= 2'd0;
      pend_r  <= 1'b0;
      oval_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      seen_r  <= seen_nxt;
      pend_r  <= pend_nxt;
      oval_r  <= oval_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    ret_r <= ret_nxt;  tgt_r <= tgt_nxt;
    t_r <= t_nxt;  px_r <= px_nxt;  py_r <= py_nxt;
    start_r <= start_nxt;  end_r <= end_nxt;
    ptime_r <= ptime_nxt;  ppx_r <= ppx_nxt;  ppy_r <= ppy_nxt;
    pvx_r <= pvx_nxt;  pvy_r <= pvy_nxt;  pax_r <= pax_nxt;  pay_r <= pay_nxt;
    vx_r <= vx_nxt;  vy_r <= vy_nxt;  ax_r <= ax_nxt;  ay_r <= ay_nxt;
    upd_r <= upd_nxt;  msel_r <= msel_nxt;
    efirst_r <= efirst_nxt;  elast_r <= elast_nxt;
    dt_r <= dt_nxt;  num_r <= num_nxt;
    sq_r <= sq_nxt;  rt_r <= rt_nxt;  k_r <= k_nxt;
    cx_r <= cx_nxt;  cy_r <= cy_nxt;  z_r <= z_nxt;
    speed_r <= speed_nxt;  amag_r <= amag_nxt;  head_r <= head_nxt;
    onset_r <= onset_nxt;  risk_r <= risk_nxt;
    dvd_r <= dvd_nxt;  dvs_r <= dvs_nxt;
  end

  // output register
  always_ff @(posedge clk) begin
    if (load_out) begin
      ovx_r <= vx_r;  ovy_r <= vy_r;  ospeed_r <= speed_r;  ohead_r <= head_r;
      oax_r <= ax_r;  oay_r <= ay_r;  oamag_r <= amag_r;  orisk_r <= risk_r;
      ofirst_r <= efirst_r;  olast_r <= elast_r;
    end
  end

  assign out_tvalid = oval_r;
  assign out_tdata  = {7'd0, orisk_r, oamag_r, oay_r, oax_r, ohead_r, ospeed_r,
                       ovy_r, ovx_r};
  assign out_tuser  = ofirst_r;
  assign out_tlast  = olast_r;

  `TKE_ASSERT_IMPL(a_div_busy_wait, dv_stat.busy, (state_r == ST_RWAIT) || (state_r == ST_E_RWAIT), "divider busy outside a wait state")
  `TKE_ASSERT_IMPL(a_pend_seen, pend_r, seen_r == 2'd1, "pending first sample without one sample seen")
  `TKE_ASSERT_NEXT(a_accept_busy, in_tvalid && in_tready, !in_tready, "sample accepted while sequencer stays idle")
endmodule
`default_nettype wire

// ===== design/tke_div.sv =====
// Restoring divider, one quotient bit per cycle.
`default_nettype none
module tke_div
  import tke_pkg::*;
#(
  parameter int DVD_W = DIV_DVD_W,
  parameter int DVS_W = DIV_DVS_W
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             go,
  input  wire logic [DVD_W-1:0] dividend,
  input  wire logic [DVS_W-1:0] divisor,
  output logic      [DVD_W-1:0] quotient,
  output tke_div_stat_t         stat
);
  localparam int CW = $clog2(DVD_W + 1);

  logic             busy_r, busy_nxt, done_r, done_nxt;
  logic [CW-1:0]    cnt_r;
  logic [DVD_W-1:0] q_r;
  logic [DVS_W-1:0] rem_r, dvs_r;
  logic [DVS_W:0]   shifted, diff;
  logic             ge;

  // trial subtraction of the shifted remainder
  assign shifted = {rem_r, q_r[DVD_W-1]};
  assign ge      = shifted >= {1'b0, dvs_r};
  assign diff    = shifted - {1'b0, dvs_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (go) begin
      busy_nxt = 1'b1;
    end else if (busy_r && cnt_r == CW'(1)) begin
      busy_nxt = 1'b0;
      done_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  // load operands, then shift in one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (go) begin
      cnt_r <= CW'(DVD_W);
      q_r   <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      cnt_r <= cnt_r - CW'(1);
      q_r   <= {q_r[DVD_W-2:0], ge};
      rem_r <= ge ? diff[DVS_W-1:0] : shifted[DVS_W-1:0];
    end
  end

  assign quotient  = q_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;
endmodule
`default_nettype wire

// ===== tb/testbench.sv =====
// Self-checking testbench for the trajectory kinematics estimator.
`default_nettype none
module testbench
  import tke_pkg::*;
();

  localparam int IDLE_PCT    = 23;
  localparam int SETTLE_CYC  = 600;
  localparam int CYCLE_LIMIT = 2000000;

  typedef struct {
    logic [31:0]        stamp;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic               new_track;
    logic               last_of_track;
  } sample_t;

  typedef struct {
    logic [31:0] vel_x;
    logic [31:0] vel_y;
    logic [31:0] speed;
    logic [15:0] heading;
    logic [31:0] acc_x;
    logic [31:0] acc_y;
    logic [31:0] acc_mag;
    logic [16:0] risk;
    logic        first;
    logic        last;
  } kin_result_t;

  logic clk;
  logic rst_n;
  logic in_tvalid, in_tready, in_tuser, in_tlast;
  logic [95:0] in_tdata;   // sample_time_us, pos_x_mm, pos_y_mm
  logic out_tvalid, out_tready, out_tuser, out_tlast;
  // vel_x, vel_y, speed_mag, heading_angle, acc_x, acc_y, acc_norm,
  // slip_risk, zero fill
  logic [231:0] out_tdata;
  logic cfg_psel, cfg_penable, cfg_pwrite, cfg_pready;
  logic [3:0]  cfg_paddr;
  logic [31:0] cfg_pwdata, cfg_prdata;

  trajectory_kinematics_estimator dut (.*);

  // Register copies
  logic [19:0] min_gap;
  logic [16:0] grip;
  logic [15:0] onset;

  // Track history copy
  logic [31:0] trk_time;
  longint      trk_px, trk_py, trk_vx, trk_vy, trk_ax, trk_ay;
  int          trk_seen;
  bit          trk_pending;

  kin_result_t expected_kin[$];
  int          err_count;
  int          cycle_count;
  bit          no_idle;

  // Free-running clock
  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  // Guard against a hung block
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Stall the result side at random, unless no_idle is set
  always @(negedge clk) begin
    out_tready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
  end

  // ---------------- prediction ----------------

  // num * 1e6 / den, rounded half away from zero, saturated
  function automatic longint rate_quot(longint num, longint den);
    longint unsigned mag, q;
    mag = (num < 0) ? longint'(-num) : num;
    mag = mag * 64'd1000000;
    q = (mag + den / 2) / den;
    if (q > 64'h80000000) q = 64'h80000000;
    if (num < 0) return -longint'(q);
    if (q > 64'h7fffffff) q = 64'h7fffffff;
    return q;
  endfunction

  function automatic logic [31:0] vec_mag(longint a, longint b);
    longint unsigned n, r, bt;
    n = longint'(a * a) + longint'(b * b);
    r = 0;
    bt = 64'd1 << 62;
    while (bt > n) bt = bt >> 2;
    while (bt != 0) begin
      if (n >= r + bt) begin
        n = n - (r + bt);
        r = (r >> 1) + bt;
      end else begin
        r = r >> 1;
      end
      bt = bt >> 2;
    end
    if (n > r) r++;
    if (r > 64'hffffffff) r = 64'hffffffff;
    return r[31:0];
  endfunction

  function automatic logic [15:0] heading_of(longint x, longint y);
    logic [31:0] z, zr;
    longint xs, ys;
    z = 0;
    if (x == 0 && y == 0) return 16'd0;
    if (x < 0) begin
      x = -x;
      y = -y;
      z = 32'h80000000;
    end
    for (int i = 0; i < 31; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x = x + ys;
        y = y - xs;
        z = z + atan_ent(5'(i));
      end else begin
        x = x - ys;
        y = y + xs;
        z = z - atan_ent(5'(i));
      end
    end
    zr = z + 32'h8000;
    return zr[31:16];
  endfunction

  function automatic logic [16:0] grip_risk(longint unsigned a);
    longint unsigned g, f, start_lvl, num, den;
    g = (grip != 0) ? grip : 1;
    f = onset;
    start_lvl = f * g;
    if (a >= g) return 17'd65536;
    if (a * 65536 <= start_lvl) return 17'd0;
    num = (a * 65536 - start_lvl) * 65536;
    den = (65536 - f) * g;
    return 17'((num + den / 2) / den);
  endfunction

  function automatic void push_kin(longint vx, longint vy, longint ax, longint ay,
                                   bit first, bit last);
    kin_result_t r;
    r.vel_x   = vx[31:0];
    r.vel_y   = vy[31:0];
    r.speed   = vec_mag(vx, vy);
    r.heading = heading_of(vx, vy);
    r.acc_x   = ax[31:0];
    r.acc_y   = ay[31:0];
    r.acc_mag = vec_mag(ax, ay);
    r.risk    = grip_risk(r.acc_mag);
    r.first   = first;
    r.last    = last;
    expected_kin.insert(expected_kin.size(), r);
  endfunction

  // Advance the track history by one accepted sample
  function automatic void predict_kin(sample_t s);
    longint px, py, dt, vx, vy, ax, ay;
    px = longint'(s.pos_x);
    py = longint'(s.pos_y);
    if (s.new_track) begin
      if (trk_pending) push_kin(0, 0, 0, 0, 1'b1, 1'b0);
      trk_seen = 0;
      trk_pending = 0;
    end
    if (trk_seen == 0) begin
      trk_time = s.stamp;
      trk_px = px;
      trk_py = py;
      trk_vx = 0;
      trk_vy = 0;
      trk_ax = 0;
      trk_ay = 0;
      if (s.last_of_track) begin
        push_kin(0, 0, 0, 0, 1'b1, 1'b1);
        trk_pending = 0;
      end else begin
        trk_seen = 1;
        trk_pending = 1;
      end
      return;
    end
    dt = longint'(s.stamp) - longint'(trk_time);
    if (dt > longint'(min_gap)) begin
      vx = rate_quot(px - trk_px, dt);
      vy = rate_quot(py - trk_py, dt);
    end else begin
      vx = trk_vx;
      vy = trk_vy;
    end
    if (trk_seen == 1) begin
      ax = 0;
      ay = 0;
      if (trk_pending) push_kin(vx, vy, 0, 0, 1'b1, 1'b0);
      trk_seen = 2;
    end else if (dt > longint'(min_gap)) begin
      ax = rate_quot(vx - trk_vx, dt);
      ay = rate_quot(vy - trk_vy, dt);
    end else begin
      ax = trk_ax;
      ay = trk_ay;
    end
    trk_pending = 0;
    push_kin(vx, vy, ax, ay, 1'b0, 1'b1);
    trk_time = s.stamp;
    trk_px = px;
    trk_py = py;
    trk_vx = vx;
    trk_vy = vy;
    trk_ax = ax;
    trk_ay = ay;
    if (s.last_of_track) begin
      trk_seen = 0;
      trk_pending = 0;
    end
  endfunction

  // ---------------- checking ----------------

  function automatic void check_field(string name, longint unsigned exp_v,
                                      longint unsigned act_v);
    if (exp_v != act_v) begin
      $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, exp_v, act_v);
      err_count++;
    end
  endfunction

  // Compare each result transfer with the oldest expectation
  always @(posedge clk) begin
    kin_result_t e;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_kin.size() == 0) begin
        $error("result transfer with no expectation waiting");
        err_count++;
      end else begin
        e = expected_kin.pop_front();
        check_field("vel_x", e.vel_x, out_tdata[31:0]);
        check_field("vel_y", e.vel_y, out_tdata[63:32]);
        check_field("speed_mag", e.speed, out_tdata[95:64]);
        check_field("heading_angle", e.heading, out_tdata[111:96]);
        check_field("acc_x", e.acc_x, out_tdata[143:112]);
        check_field("acc_y", e.acc_y, out_tdata[175:144]);
        check_field("acc_norm", e.acc_mag, out_tdata[207:176]);
        check_field("slip_risk", e.risk, out_tdata[224:208]);
        check_field("zero_fill", 0, out_tdata[231:225]);
        check_field("is_first_sample", e.first, out_tuser);
        check_field("run_last", e.last, out_tlast);
      end
    end
  end

  // ---------------- stimulus ----------------

  task automatic send_sample(sample_t s);
    @(negedge clk);
    while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {s.pos_y, s.pos_x, s.stamp};
    in_tuser  <= s.new_track;
    in_tlast  <= s.last_of_track;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_kin(s);
  endtask

  // Hold off input until every expected result has arrived
  task automatic drain_results();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (expected_kin.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= val;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    case (idx)
      REG_MIN_INTERVAL: min_gap = val[19:0];
      REG_GRIP_LIMIT:   grip    = val[16:0];
      REG_RISK_ONSET:   onset   = val[15:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  task automatic set_regs(logic [31:0] gap, logic [31:0] g, logic [31:0] f);
    drain_results();
    write_reg(REG_MIN_INTERVAL, gap);
    write_reg(REG_GRIP_LIMIT, g);
    write_reg(REG_RISK_ONSET, f);
  endtask

  task automatic send_one(logic [31:0] t, logic [31:0] x, logic [31:0] y,
                          bit st, bit en);
    sample_t s;
    s.stamp = t;
    s.pos_x = x;
    s.pos_y = y;
    s.new_track = st;
    s.last_of_track = en;
    send_sample(s);
  endtask

  // Lone sample, pending first cut by a new track, track end without start
  task automatic test_track_framing();
    send_one(32'd5000, 32'd10, -32'sd10, 1'b1, 1'b1);
    send_one(32'd100, 32'd0, 32'd0, 1'b1, 1'b0);
    send_one(32'd200, 32'd7, 32'd7, 1'b1, 1'b0);
    send_one(32'd9000, 32'd7, 32'd7, 1'b0, 1'b0);
    send_one(32'd20000, 32'd300, -32'sd50, 1'b0, 1'b1);
    send_one(32'd30000, 32'd1, 32'd2, 1'b0, 1'b0);
    send_one(32'd40000, -32'sd900, 32'd2, 1'b0, 1'b1);
  endtask

  // Saturation, step at the limit, backwards and wrapped time stamps
  task automatic test_extremes();
    send_one(32'd0, 32'h7fffffff, 32'h80000000, 1'b1, 1'b0);
    send_one(32'd1001, 32'h80000000, 32'h7fffffff, 1'b0, 1'b0);
    send_one(32'd2002, 32'h7fffffff, 32'h80000000, 1'b0, 1'b0);
    send_one(32'd3002, 32'd0, 32'd0, 1'b0, 1'b0);
    send_one(32'd2500, 32'd5, 32'd5, 1'b0, 1'b1);
    send_one(32'hfffffff0, 32'd100, 32'd100, 1'b1, 1'b0);
    send_one(32'h00000010, 32'd200, 32'd200, 1'b0, 1'b0);
    send_one(32'd0, -32'sd1, 32'd0, 1'b1, 1'b0);
    send_one(32'hffffffff, 32'd1, -32'sd1, 1'b0, 1'b0);
    send_one(32'hffffffff, 32'd1, -32'sd1, 1'b0, 1'b1);
  endtask

  // Slow motion with a wide window so the risk lands between its bounds
  task automatic test_risk_ramp();
    set_regs(32'd0, 32'd100000, 32'd0);
    send_one(32'd0, 32'd0, 32'd0, 1'b1, 1'b0);
    send_one(32'd1000000, 32'd1000, 32'd0, 1'b0, 1'b0);
    send_one(32'd2000000, 32'd41000, 32'd0, 1'b0, 1'b0);
    send_one(32'd2000001, 32'd41000, 32'd0, 1'b0, 1'b0);
    send_one(32'd3000000, 32'd40000, -32'sd20000, 1'b0, 1'b1);
    set_regs(32'd1000000, 32'd0, 32'd65535);
    send_one(32'd0, 32'd0, 32'd0, 1'b1, 1'b0);
    send_one(32'd1000000, 32'd50, 32'd0, 1'b0, 1'b0);
    send_one(32'd2000001, 32'd90, 32'd40, 1'b0, 1'b1);
  endtask

  task automatic random_track(int len, bit slow);
    sample_t s;
    int      step, r;
    longint  walk_x, walk_y;
    s.stamp = $urandom;
    s.pos_x = $urandom;
    s.pos_y = $urandom;
    walk_x = longint'($urandom_range(20000)) - 10000;
    walk_y = longint'($urandom_range(20000)) - 10000;
    for (int k = 0; k < len; k++) begin
      if (k > 0) begin
        r = $urandom_range(99);
        if (r < 8) step = min_gap;
        else if (r < 14) step = $urandom_range(min_gap);
        else if (r < 18) step = -int'($urandom_range(1, 5000));
        else if (slow) step = $urandom_range(900000, 1100000);
        else step = min_gap + $urandom_range(1, 40000);
        s.stamp = s.stamp + step;
        walk_x = walk_x + longint'($urandom_range(18000)) - 9000;
        walk_y = walk_y + longint'($urandom_range(18000)) - 9000;
        s.pos_x = s.pos_x + 32'(walk_x * step / 1000000);
        s.pos_y = s.pos_y + 32'(walk_y * step / 1000000);
      end
      s.new_track = (k == 0) ? ($urandom_range(99) < 85) : ($urandom_range(99) < 3);
      s.last_of_track = (k == len - 1) ? ($urandom_range(99) < 85) : 1'b0;
      if ($urandom_range(99) < 8) begin
        // Raw noise with every field random
        send_one($urandom, $urandom, $urandom, $urandom_range(1), $urandom_range(1));
      end
      send_sample(s);
    end
  endtask

  task automatic test_random_phase(int items);
    int sent, len;
    sent = 0;
    while (sent < items) begin
      len = $urandom_range(1, 7);
      random_track(len, $urandom_range(99) < 30);
      sent += len;
    end
  endtask

  task automatic test_random_settings();
    test_random_phase(100);
    set_regs(32'd0, 32'd100000, 32'd0);
    test_random_phase(100);
    no_idle = 1'b1;
    set_regs(32'd1000000, 32'd1, 32'd65535);
    test_random_phase(100);
    no_idle = 1'b0;
    set_regs($urandom_range(1000000), 32'd0, $urandom_range(65535));
    test_random_phase(100);
    set_regs(32'd1000, $urandom_range(1, 100000), $urandom_range(65535));
    test_random_phase(100);
  endtask

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = 1'b0;
    in_tlast = 1'b0;
    out_tready = 1'b0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    min_gap = MIN_INTERVAL_RST;
    grip = GRIP_LIMIT_RST;
    onset = RISK_ONSET_RST;
    trk_time = 0;
    trk_px = 0;
    trk_py = 0;
    trk_vx = 0;
    trk_vy = 0;
    trk_ax = 0;
    trk_ay = 0;
    trk_seen = 0;
    trk_pending = 0;
    err_count = 0;
    cycle_count = 0;
    no_idle = 1'b0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    test_track_framing();
    test_extremes();
    test_risk_ramp();
    set_regs(32'd1000, 32'd7848, 32'd39322);
    test_random_settings();

    drain_results();
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ===== trajectory_kinematics_estimator.f =====
+incdir+design
design/tke_pkg.sv
design/tke_div.sv
design/trajectory_kinematics_estimator.sv
tb/testbench.sv
